FILE: design/otcc_pkg.sv
// ----------------------------------------------------------------------------
// otcc_pkg
// Shared codes and fixed widths of the obstacle table collision check unit.
// ----------------------------------------------------------------------------
package otcc_pkg;

    // Beat kinds carried on the input tuser
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_SEG  = 2'd1;
    localparam logic [1:0] MODE_BOX  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_COUNT = 2'd0;
    localparam logic [1:0] CFG_TOL   = 2'd1;

    // Slab parameter: 32 fraction bits, saturated to 2.0
    localparam int T_FRAC_BITS = 32;
    localparam logic signed [34:0] T_ONE = 35'sh1_0000_0000;
    localparam logic [33:0]        T_SAT = 34'h2_0000_0000;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [33:0] t_bound;
    typedef logic signed [34:0] t_slab;

endpackage

FILE: design/obstacle_table_collision_check_unit.sv
// ----------------------------------------------------------------------------
// obstacle_table_collision_check_unit
// Obstacle box table with segment slab tests and box overlap tests.
// ----------------------------------------------------------------------------
// One beat is handled at a time; the input is not ready until the beat's
// result is registered. A load writes its six words into the table memory,
// one per cycle. A query walks the first min(obstacle_count, MAX_OBSTACLES)
// entries and stops at the first hit. Each box query axis takes two table
// reads, the registered read and one compare. Each segment query axis takes
// the same table reads and compare, then two slab divisions on the one
// shared restoring divider (one quotient bit per cycle), then an interval
// update; an axis with zero direction takes only the reads and compare.
// Table entries are undefined until loaded; there is no clearing pass. The
// result beat sits in an output register, so the next input beat can be
// taken while it waits.
// ----------------------------------------------------------------------------
module obstacle_table_collision_check_unit #(
    parameter int MAX_OBSTACLES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input beat
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata, low bit up: slot[6], x0[32], y0[32], z0[32], x1[32], y1[32],
    // z1[32], radius[31], zero pad[3]
    input  logic [231:0] i_s_axis_tdata,
    // tuser: mode[2]
    input  logic [1:0]   i_s_axis_tuser,
    // tlast: end_of_group
    input  logic         i_s_axis_tlast,
    // Result beat
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata, low bit up: hit[1], group_hit[1], zero pad[6]
    output logic [7:0]   o_m_axis_tdata,
    // Configuration write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int DEPTH = MAX_OBSTACLES * 6;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_OBSTACLES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_RLO   = 4'd2;
    localparam logic [3:0] S_RHI   = 4'd3;
    localparam logic [3:0] S_AX    = 4'd4;
    localparam logic [3:0] S_EVAL  = 4'd5;
    localparam logic [3:0] S_DINIT = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DDONE = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_CHK   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    // Table memory
    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    // Control
    logic [3:0]    r_state, n_state;
    logic [6:0]    r_count;
    logic [30:0]   r_tol;
    logic          r_group_any;
    logic          r_out_valid, r_out_hit, r_out_gh;

    // Beat held for the walk
    logic [1:0]    r_mode;
    logic          r_eog;
    otcc_pkg::t_coord r_p0 [3];
    otcc_pkg::t_coord r_p1 [3];
    logic [31:0]   r_rad;
    logic [IW-1:0] r_n, r_idx;
    logic [AW-1:0] r_base;
    logic [1:0]    r_axis;
    logic [2:0]    r_widx;
    logic          r_hit;

    // Slab evaluation
    otcc_pkg::t_bound r_lo, r_hi;
    otcc_pkg::t_slab  r_enter, r_leave, r_t0, r_t1;
    logic [34:0]   r_num;
    logic signed [32:0] r_den;
    logic          r_half;

    // Shared divider
    logic [34:0]   r_rem;
    logic [34:0]   r_dmag;
    logic [33:0]   r_q;
    logic          r_neg;
    logic [5:0]    r_step;

    // ---- input field unpack ----
    logic [5:0]  w_slot;
    logic [30:0] w_radius;
    assign w_slot   = i_s_axis_tdata[5:0];
    assign w_radius = i_s_axis_tdata[228:198];

    logic w_in_fire, w_out_fire, w_fin_go;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_fire = r_out_valid && i_m_axis_tready;
    assign w_fin_go   = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_gh, r_out_hit};

    // ---- capture-time values ----
    logic signed [31:0] w_rad_raw;
    logic [31:0] w_n_full, w_base_full;
    logic        w_slot_ok;
    assign w_rad_raw   = $signed({1'b0, w_radius}) - $signed({1'b0, r_tol});
    assign w_n_full    = ({25'b0, r_count} > 32'(MAX_OBSTACLES)) ?
                         32'(MAX_OBSTACLES) : {25'b0, r_count};
    assign w_slot_ok   = {26'b0, w_slot} < 32'(MAX_OBSTACLES);
    assign w_base_full = ({26'b0, w_slot} << 2) + ({26'b0, w_slot} << 1);

    // ---- per-axis selection ----
    otcc_pkg::t_coord   w_s, w_e;
    logic signed [32:0] w_d;
    otcc_pkg::t_bound   w_word, w_radx;
    always_comb begin
        case (r_axis)
            2'd0:    begin w_s = r_p0[0]; w_e = r_p1[0]; end
            2'd1:    begin w_s = r_p0[1]; w_e = r_p1[1]; end
            default: begin w_s = r_p0[2]; w_e = r_p1[2]; end
        endcase
    end
    assign w_d    = {w_e[31], w_e} - {w_s[31], w_s};
    assign w_word = {{2{r_rdata[31]}}, r_rdata};
    assign w_radx = {2'b0, r_rad};

    logic signed [34:0] w_s35;
    assign w_s35 = {{3{w_s[31]}}, w_s};

    // ---- divider start values ----
    logic [34:0] w_nmag, w_dmag;
    assign w_nmag = r_num[34] ? (35'd0 - r_num) : r_num;
    assign w_dmag = r_den[32] ? (35'd0 - {{2{r_den[32]}}, r_den}) : {2'b0, r_den};

    logic [34:0] w_rem_sh;
    assign w_rem_sh = {r_rem[33:0], 1'b0};

    otcc_pkg::t_slab w_t, w_tmin, w_tmax;
    assign w_t    = r_neg ? (35'sd0 - $signed({1'b0, r_q})) : $signed({1'b0, r_q});
    assign w_tmin = (r_t0 > r_t1) ? r_t1 : r_t0;
    assign w_tmax = (r_t0 > r_t1) ? r_t0 : r_t1;

    logic w_last_obst;
    assign w_last_obst = (r_idx + IW'(1)) == r_n;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_s_axis_tuser == otcc_pkg::MODE_LOAD && w_slot_ok)
                        n_state = S_LOAD;
                    else if ((i_s_axis_tuser == otcc_pkg::MODE_SEG ||
                              i_s_axis_tuser == otcc_pkg::MODE_BOX) &&
                             w_n_full != 32'd0)
                        n_state = S_RLO;
                    else
                        n_state = S_FIN;
                end
            end
            S_LOAD:  if (r_widx == 3'd5) n_state = S_FIN;
            S_RLO:   n_state = S_RHI;
            S_RHI:   n_state = S_AX;
            S_AX:    n_state = S_EVAL;
            S_EVAL: begin
                if (r_mode == otcc_pkg::MODE_BOX || w_d == 33'sd0) begin
                    if ((r_mode == otcc_pkg::MODE_BOX) ?
                        ($signed({{2{w_e[31]}}, w_e}) < r_lo ||
                         $signed({{2{w_s[31]}}, w_s}) > r_hi) :
                        ($signed({{2{w_s[31]}}, w_s}) < r_lo ||
                         $signed({{2{w_s[31]}}, w_s}) > r_hi))
                        n_state = w_last_obst ? S_FIN : S_RLO;
                    else
                        n_state = (r_axis == 2'd2) ? S_FIN : S_RLO;
                end else begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: n_state = (w_nmag >= (w_dmag << 1)) ? S_DDONE : S_DIV;
            S_DIV:   if (r_step == 6'd1) n_state = S_DDONE;
            S_DDONE: n_state = r_half ? S_CMP : S_DINIT;
            S_CMP:   n_state = S_CHK;
            S_CHK: begin
                if (r_enter > r_leave)
                    n_state = w_last_obst ? S_FIN : S_RLO;
                else
                    n_state = (r_axis == 2'd2) ? S_FIN : S_RLO;
            end
            S_FIN:   if (w_fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Axis outcome, shared by the box compare, zero direction and slab check
    logic w_ax_fail, w_ax_done;
    assign w_ax_fail = (r_state == S_EVAL && n_state != S_DINIT &&
                        ((r_mode == otcc_pkg::MODE_BOX) ?
                         ($signed({{2{w_e[31]}}, w_e}) < r_lo ||
                          $signed({{2{w_s[31]}}, w_s}) > r_hi) :
                         ($signed({{2{w_s[31]}}, w_s}) < r_lo ||
                          $signed({{2{w_s[31]}}, w_s}) > r_hi))) ||
                       (r_state == S_CHK && r_enter > r_leave);
    assign w_ax_done = ((r_state == S_EVAL && n_state != S_DINIT) ||
                        r_state == S_CHK) && !w_ax_fail;

    // Table memory: one write, one registered read
    logic [AW-1:0] w_raddr;
    assign w_raddr = (r_state == S_RHI) ? (r_base + AW'(r_axis) + AW'(3)) :
                                          (r_base + AW'(r_axis));
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD)
            mem[r_base + AW'(r_widx)] <= (r_widx < 3'd3) ?
                r_p0[r_widx[1:0]] : r_p1[2'(r_widx - 3'd3)];
        r_rdata <= mem[w_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= 7'd0;
            r_tol       <= 31'd0;
            r_group_any <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    otcc_pkg::CFG_COUNT: r_count <= i_cfg_data[6:0];
                    otcc_pkg::CFG_TOL:   r_tol   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // Hold the result until taken; a new one lands only in a free slot
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
                if (r_mode == otcc_pkg::MODE_SEG || r_mode == otcc_pkg::MODE_BOX)
                    r_group_any <= (r_hit || r_group_any) && !r_eog;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out_hit <= r_hit;
            r_out_gh  <= r_hit || r_group_any;
        end
        case (r_state)
            S_IDLE: begin
                r_mode  <= i_s_axis_tuser;
                r_eog   <= i_s_axis_tlast;
                r_p0[0] <= i_s_axis_tdata[37:6];
                r_p0[1] <= i_s_axis_tdata[69:38];
                r_p0[2] <= i_s_axis_tdata[101:70];
                r_p1[0] <= i_s_axis_tdata[133:102];
                r_p1[1] <= i_s_axis_tdata[165:134];
                r_p1[2] <= i_s_axis_tdata[197:166];
                // Box queries test the raw boxes; drop the inflation
                r_rad   <= (i_s_axis_tuser != otcc_pkg::MODE_SEG || w_rad_raw < 0) ?
                           32'd0 : w_rad_raw;
                r_n     <= w_n_full[IW-1:0];
                r_idx   <= '0;
                r_axis  <= 2'd0;
                r_widx  <= 3'd0;
                r_hit   <= 1'b0;
                r_enter <= '0;
                r_leave <= otcc_pkg::T_ONE;
                r_base  <= (i_s_axis_tuser == otcc_pkg::MODE_LOAD) ?
                           w_base_full[AW-1:0] : '0;
            end
            S_LOAD:  r_widx <= r_widx + 3'd1;
            S_RHI:   r_lo   <= w_word - w_radx;
            S_AX:    r_hi   <= w_word + w_radx;
            S_EVAL: begin
                r_num  <= $signed({r_lo[33], r_lo}) - w_s35;
                r_den  <= w_d;
                r_half <= 1'b0;
            end
            S_DINIT: begin
                r_neg  <= r_num[34] != r_den[32];
                r_dmag <= w_dmag;
                r_step <= 6'(otcc_pkg::T_FRAC_BITS);
                if (w_nmag >= (w_dmag << 1)) begin
                    r_q <= otcc_pkg::T_SAT;
                end else if (w_nmag >= w_dmag) begin
                    r_q   <= 34'd1;
                    r_rem <= w_nmag - w_dmag;
                end else begin
                    r_q   <= 34'd0;
                    r_rem <= w_nmag;
                end
            end
            S_DIV: begin
                r_step <= r_step - 6'd1;
                if (w_rem_sh >= r_dmag) begin
                    r_rem <= w_rem_sh - r_dmag;
                    r_q   <= {r_q[32:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_q   <= {r_q[32:0], 1'b0};
                end
            end
            S_DDONE: begin
                if (!r_half) begin
                    r_t0   <= w_t;
                    r_num  <= $signed({r_hi[33], r_hi}) - w_s35;
                    r_half <= 1'b1;
                end else begin
                    r_t1 <= w_t;
                end
            end
            S_CMP: begin
                if (w_tmin > r_enter) r_enter <= w_tmin;
                if (w_tmax < r_leave) r_leave <= w_tmax;
            end
            default: ;
        endcase
        // Advance axis or obstacle after an axis outcome
        if (w_ax_fail) begin
            r_idx   <= r_idx + IW'(1);
            r_base  <= r_base + AW'(6);
            r_axis  <= 2'd0;
            r_enter <= '0;
            r_leave <= otcc_pkg::T_ONE;
        end else if (w_ax_done) begin
            if (r_axis == 2'd2) r_hit  <= 1'b1;
            else                r_axis <= r_axis + 2'd1;
        end
    end

    // ---- assertions ----
    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step != 6'd0))
        else $error("divider iterating with no steps left");

    a_hit_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (!o_m_axis_tdata[0] || o_m_axis_tdata[1]))
        else $error("hit without group hit");

    a_enter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_enter >= 0 && r_leave <= otcc_pkg::T_ONE))
        else $error("slab interval left [0,1]");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_m_axis_tready) |=> (r_state == S_FIN))
        else $error("result overwrote a pending beat");

endmodule
